// File: rtl/tkv_pkg.sv
// tkv_pkg: shared types and constants for the key/value cache with expiry
// used by tkv_cell and ttl_key_value_ring_cache; no dependencies
package tkv_pkg;

  // default sizes for the top-level parameters
  localparam int unsigned ENTRIES_DEF   = 16;
  localparam int unsigned KEY_BITS_DEF  = 64;
  localparam int unsigned DATA_BITS_DEF = 64;

  // fixed field widths
  localparam int unsigned OP_BITS      = 2;
  localparam int unsigned NOW_BITS     = 32;
  localparam int unsigned TIMEOUT_BITS = 31;

  // request operation codes
  typedef enum logic [OP_BITS-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // control states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_SEARCH = 2'b10
  } state_t;

endpackage

// File: rtl/tkv_cell.sv
// tkv_cell: one cache line of the shifting line chain plus one stage of the
// search chain; depends on tkv_pkg
module tkv_cell
  import tkv_pkg::*;
#(
  parameter int unsigned KEY_BITS  = KEY_BITS_DEF,
  parameter int unsigned DATA_BITS = DATA_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  // line chain, moves one place older on each insert
  input  logic                    shift,
  input  logic                    valid_prev,
  input  logic [KEY_BITS-1:0]     key_prev,
  input  logic [DATA_BITS-1:0]    data_prev,
  input  logic [NOW_BITS-1:0]     created_prev,
  output logic                    valid,
  output logic [KEY_BITS-1:0]     line_key,
  output logic [DATA_BITS-1:0]    line_data,
  output logic [NOW_BITS-1:0]     created,
  // broadcast search terms
  input  logic [KEY_BITS-1:0]     srch_key,
  input  logic [NOW_BITS-1:0]     now_ticks,
  input  logic [TIMEOUT_BITS-1:0] timeout_ticks,
  // search chain, newer result from the previous cell
  input  logic                    hit_prev,
  input  logic [DATA_BITS-1:0]    hit_data_prev,
  output logic                    hit,
  output logic [DATA_BITS-1:0]    hit_data
);

  logic [NOW_BITS-1:0] age;
  logic                match;

  assign age   = now_ticks - created;
  assign match = valid && (line_key == srch_key) &&
                 (age <= {1'b0, timeout_ticks});

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= valid_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      line_key  <= key_prev;
      line_data <= data_prev;
      created   <= created_prev;
    end
  end

  // a newer hit passes through untouched
  always_ff @(posedge clk) begin
    hit <= hit_prev || match;
    if (hit_prev) begin
      hit_data <= hit_data_prev;
    end else if (match) begin
      hit_data <= line_data;
    end else begin
      hit_data <= '0;
    end
  end

endmodule

// File: rtl/ttl_key_value_ring_cache.sv
// ttl_key_value_ring_cache: top level of the key/value cache with fifo
// replacement and expiry; depends on tkv_pkg and tkv_cell
//
// The cache keeps ENTRIES lines in a chain of cells, newest in cell 0. An
// insert shifts every line one cell older and writes key, data and the
// current tick count into cell 0; the oldest line falls off the end, which
// is exactly round-robin replacement. A tick bumps the 32-bit
// tick counter. Inserts, ticks and the unused op code keep the block idle,
// so a new request can be taken in the next cycle. A lookup freezes the lines
// and sends its result down the search chain, one cell per cycle, newest
// first, so the first fresh match wins. The chain length sets the lookup
// time, and the next request can be taken in the same cycle as the result
// is offered, even while the result still waits in the output register. A
// lookup whose search ends while an older result still waits holds in the
// search state until that result is taken.
// A line hits when it is valid, its key is equal and its age (now minus
// created, modulo 2^32) is not above timeout_ticks; data_out is zero on a
// miss. The configuration write is always ready and is meant for idle time.
module ttl_key_value_ring_cache
  import tkv_pkg::*;
#(
  parameter int unsigned ENTRIES   = ENTRIES_DEF,
  parameter int unsigned KEY_BITS  = KEY_BITS_DEF,
  parameter int unsigned DATA_BITS = DATA_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  // configuration write
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [TIMEOUT_BITS-1:0] cfg_data,
  // request channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [OP_BITS-1:0]      op,
  input  logic [KEY_BITS-1:0]     key,
  input  logic [DATA_BITS-1:0]    data_in,
  // result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    hit,
  output logic [DATA_BITS-1:0]    data_out
);

  localparam int unsigned CNT_BITS = $clog2(ENTRIES + 1);

  // control and shared registers
  state_t                state;
  state_t                state_next;
  logic [CNT_BITS-1:0]   cnt;
  logic [TIMEOUT_BITS-1:0] timeout_ticks;
  logic [NOW_BITS-1:0]   now_ticks;
  logic [KEY_BITS-1:0]   srch_key;

  logic                  in_fire;
  logic                  ins_fire;
  logic                  tick_fire;
  logic                  look_fire;
  logic                  search_done;
  logic                  out_load;

  // line chain taps, index is the cell
  logic                  line_valid   [ENTRIES];
  logic [KEY_BITS-1:0]   line_key     [ENTRIES];
  logic [DATA_BITS-1:0]  line_data    [ENTRIES];
  logic [NOW_BITS-1:0]   line_created [ENTRIES];

  // search chain taps
  logic                  chain_hit    [ENTRIES];
  logic [DATA_BITS-1:0]  chain_data   [ENTRIES];

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);

  assign in_fire   = in_valid && in_ready;
  assign ins_fire  = in_fire && (op_t'(op) == OP_INSERT);
  assign tick_fire = in_fire && (op_t'(op) == OP_TICK);
  assign look_fire = in_fire && (op_t'(op) == OP_LOOKUP);

  // search chain has settled once the count runs out
  assign search_done = (state == ST_SEARCH) && (cnt == '0);
  // the output register takes a new result only when it is free
  assign out_load    = search_done && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (look_fire) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // walks the search through the chain, one cell per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (look_fire) begin
      cnt <= CNT_BITS'(ENTRIES);
    end else if ((state == ST_SEARCH) && (cnt != '0)) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (look_fire) begin
      srch_key <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= '0;
    end else if (cfg_valid && cfg_ready) begin
      timeout_ticks <= cfg_data;
    end
  end

  // tick counter, steps by one on each tick and wraps modulo 2^32
  always_ff @(posedge clk) begin
    if (rst) begin
      now_ticks <= '0;
    end else if (tick_fire) begin
      now_ticks <= now_ticks + 1'b1;
    end
  end

  // output register, holds a result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      hit      <= chain_hit[ENTRIES-1];
      data_out <= chain_data[ENTRIES-1];
    end
  end

  // row of cells, cell 0 holds the newest line
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic                 valid_prev;
    logic [KEY_BITS-1:0]  key_prev;
    logic [DATA_BITS-1:0] data_prev;
    logic [NOW_BITS-1:0]  created_prev;
    logic                 hit_prev;
    logic [DATA_BITS-1:0] hit_data_prev;

    if (i == 0) begin : g_head
      // new line enters here, the search starts with a miss
      assign valid_prev    = 1'b1;
      assign key_prev      = key;
      assign data_prev     = data_in;
      assign created_prev  = now_ticks;
      assign hit_prev      = 1'b0;
      assign hit_data_prev = '0;
    end else begin : g_link
      assign valid_prev    = line_valid[i-1];
      assign key_prev      = line_key[i-1];
      assign data_prev     = line_data[i-1];
      assign created_prev  = line_created[i-1];
      assign hit_prev      = chain_hit[i-1];
      assign hit_data_prev = chain_data[i-1];
    end

    tkv_cell #(
      .KEY_BITS  (KEY_BITS),
      .DATA_BITS (DATA_BITS)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .shift         (ins_fire),
      .valid_prev    (valid_prev),
      .key_prev      (key_prev),
      .data_prev     (data_prev),
      .created_prev  (created_prev),
      .valid         (line_valid[i]),
      .line_key      (line_key[i]),
      .line_data     (line_data[i]),
      .created       (line_created[i]),
      .srch_key      (srch_key),
      .now_ticks     (now_ticks),
      .timeout_ticks (timeout_ticks),
      .hit_prev      (hit_prev),
      .hit_data_prev (hit_data_prev),
      .hit           (chain_hit[i]),
      .hit_data      (chain_data[i])
    );
  end

  // a lookup starts a full walk of the chain
  a_lookup_starts: assert property (@(posedge clk) disable iff (rst)
    look_fire |=> (state == ST_SEARCH) && (cnt == CNT_BITS'(ENTRIES)))
    else $error("lookup did not start a full search");

  // an insert leaves a valid newest line
  a_insert_head: assert property (@(posedge clk) disable iff (rst)
    ins_fire |=> line_valid[0])
    else $error("insert did not fill the newest line");

  // only a tick moves time, by one
  a_tick_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (now_ticks != $past(now_ticks)) |->
      $past(tick_fire) && (now_ticks == $past(now_ticks) + 1'b1))
    else $error("tick counter moved without a tick");

  // a new result comes only from a settled search
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $rose(out_valid) |-> $past(search_done))
    else $error("result offered before the search settled");

endmodule

// File: dv/tb_ttl_key_value_ring_cache.sv
// tb_ttl_key_value_ring_cache: self-checking testbench for the fifo-replacement
// key/value cache with expiry; a directed table, then random phases
// depends on tkv_pkg and the ttl_key_value_ring_cache rtl only
module tb_ttl_key_value_ring_cache;
  timeunit 1ns;
  timeprecision 1ps;

  import tkv_pkg::*;

  localparam int unsigned LINES = ENTRIES_DEF;
  localparam int unsigned KW = KEY_BITS_DEF;
  localparam int unsigned DW = DATA_BITS_DEF;
  // quiet wait after the last answer, longer than a lookup takes
  localparam int unsigned DRAIN_CYCLES = LINES + 8;
  localparam int unsigned PHASES = 8;
  localparam int unsigned REQUESTS_PER_PHASE = 230;
  localparam int unsigned KEY_POOL_SIZE = 10;
  localparam logic [TIMEOUT_BITS-1:0] AGE_LIMIT_MAX = {TIMEOUT_BITS{1'b1}};
  localparam logic [KW-1:0] KEY_ONES = {KW{1'b1}};
  localparam logic [DW-1:0] DATA_ONES = {DW{1'b1}};

  // one lookup answer: hit flag and the data of the newest fresh line
  typedef struct packed {
    logic          hit;
    logic [DW-1:0] data;
  } lookup_result_t;

  // one row of the directed table; pinned rows carry a hand-written answer
  typedef struct packed {
    logic [OP_BITS-1:0] op;
    logic [KW-1:0]      key;
    logic [DW-1:0]      data;
    bit                 pinned;
    lookup_result_t     answer;
  } directed_row_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [TIMEOUT_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_BITS-1:0] op = OP_NONE;
  logic [KW-1:0] key = '0;
  logic [DW-1:0] data_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic hit;
  logic [DW-1:0] data_out;

  // shadow copy of the cache lines, the slot pointer, time and the age limit
  bit                  shadow_live [LINES];
  logic [KW-1:0]       shadow_key [LINES];
  logic [DW-1:0]       shadow_data [LINES];
  logic [NOW_BITS-1:0] shadow_born [LINES];
  int unsigned         shadow_slot = 0;
  logic [NOW_BITS-1:0] shadow_now = '0;
  logic [TIMEOUT_BITS-1:0] age_limit = '0;

  lookup_result_t pending_answers[$];
  directed_row_t  directed_rows[$];
  logic [KW-1:0]  key_pool [KEY_POOL_SIZE];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned errors = 0;

  ttl_key_value_ring_cache uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .key       (key),
    .data_in   (data_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit       (hit),
    .data_out  (data_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("tb_ttl_key_value_ring_cache: FAIL");
    $finish;
  end

  // newest-first scan of the shadow lines for a fresh line with this key
  function automatic lookup_result_t newest_fresh_line(logic [KW-1:0] k);
    lookup_result_t r;
    int unsigned pos;
    logic [NOW_BITS-1:0] age;
    r = '0;
    for (int n = 1; n <= LINES; n++) begin
      pos = (shadow_slot + LINES - n) % LINES;
      age = shadow_now - shadow_born[pos];
      if (shadow_live[pos] && shadow_key[pos] == k && age <= {1'b0, age_limit}) begin
        r.hit = 1'b1;
        r.data = shadow_data[pos];
        return r;
      end
    end
    return r;
  endfunction

  // apply one taken request to the shadow state; lookups queue their answer
  function automatic void absorb_request(logic [OP_BITS-1:0] o, logic [KW-1:0] k,
                                         logic [DW-1:0] d, bit pinned,
                                         lookup_result_t answer);
    case (o)
      OP_INSERT: begin
        shadow_live[shadow_slot] = 1'b1;
        shadow_key[shadow_slot] = k;
        shadow_data[shadow_slot] = d;
        shadow_born[shadow_slot] = shadow_now;
        shadow_slot = (shadow_slot + 1) % LINES;
      end
      OP_TICK: shadow_now = shadow_now + 1'b1;
      OP_LOOKUP: pending_answers.push_back(pinned ? answer : newest_fresh_line(k));
      default: ;  // unused op code leaves everything alone
    endcase
  endfunction

  function automatic void add_row(logic [OP_BITS-1:0] o, logic [KW-1:0] k,
                                  logic [DW-1:0] d, bit pinned, logic h,
                                  logic [DW-1:0] answer_data);
    directed_row_t row;
    row.op = o;
    row.key = k;
    row.data = d;
    row.pinned = pinned;
    row.answer.hit = h;
    row.answer.data = answer_data;
    directed_rows.push_back(row);
  endfunction

  // present one request, holding it until taken; valid stays high when the
  // next request follows without a gap
  task automatic send_request(logic [OP_BITS-1:0] o, logic [KW-1:0] k,
                              logic [DW-1:0] d, bit pinned, lookup_result_t answer);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    key <= k;
    data_in <= d;
    do @(posedge clk); while (in_ready !== 1'b1);
    absorb_request(o, k, d, pinned, answer);
  endtask

  // drop valid, let every lookup answer come back, then let the block settle
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_age_limit(logic [TIMEOUT_BITS-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    age_limit = v;
    cfg_valid <= 1'b0;
  endtask

  // result side: random back-pressure and in-order compare of lookup answers
  always @(posedge clk) begin : answer_check
    lookup_result_t want;
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: answer with no lookup waiting: hit %b data_out %h",
                 $time, hit, data_out);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (hit !== want.hit) begin
          $display("%0t: hit expected %b actual %b", $time, want.hit, hit);
          errors++;
        end
        if (data_out !== want.data) begin
          $display("%0t: data_out expected %h actual %h", $time, want.data, data_out);
          errors++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin : stimulus
    int unsigned taken;
    int unsigned roll;
    logic [OP_BITS-1:0] o;
    logic [KW-1:0] k;
    logic [DW-1:0] d;
    logic [TIMEOUT_BITS-1:0] limit_setting;

    for (int i = 0; i < LINES; i++) shadow_live[i] = 1'b0;
    // a small set of keys so that random lookups find their inserts
    key_pool[0] = '0;
    key_pool[1] = KEY_ONES;
    for (int i = 2; i < KEY_POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed table, age limit still at its reset value of zero
    // empty cache misses on both key extremes
    add_row(OP_LOOKUP, '0, '0, 1, 1'b0, '0);
    add_row(OP_LOOKUP, KEY_ONES, '0, 1, 1'b0, '0);
    // unused op code must neither answer nor store
    add_row(OP_NONE, KEY_ONES, DATA_ONES, 0, 1'b0, '0);
    add_row(OP_INSERT, '0, DATA_ONES, 0, 1'b0, '0);
    add_row(OP_LOOKUP, '0, '0, 1, 1'b1, DATA_ONES);
    add_row(OP_INSERT, KEY_ONES, '0, 0, 1'b0, '0);
    add_row(OP_LOOKUP, KEY_ONES, '0, 1, 1'b1, '0);
    add_row(OP_LOOKUP, '0, '0, 1, 1'b1, DATA_ONES);
    // one tick ages every line past a zero limit
    add_row(OP_TICK, '0, '0, 0, 1'b0, '0);
    add_row(OP_LOOKUP, '0, '0, 1, 1'b0, '0);
    // duplicate keys: the newer line wins
    add_row(OP_INSERT, 64'h0123_4567_89ab_cdef, 64'h1111_2222_3333_4444, 0, 1'b0, '0);
    add_row(OP_INSERT, 64'h0123_4567_89ab_cdef, 64'h5555_6666_7777_8888, 0, 1'b0, '0);
    add_row(OP_LOOKUP, 64'h0123_4567_89ab_cdef, '0, 1, 1'b1, 64'h5555_6666_7777_8888);
    add_row(OP_TICK, KEY_ONES, DATA_ONES, 0, 1'b0, '0);
    add_row(OP_LOOKUP, 64'h0123_4567_89ab_cdef, '0, 1, 1'b0, '0);
    add_row(OP_INSERT, 64'h0123_4567_89ab_cdef, 64'h9999_aaaa_bbbb_cccc, 0, 1'b0, '0);
    add_row(OP_LOOKUP, 64'h0123_4567_89ab_cdef, '0, 0, 1'b0, '0);
    add_row(OP_NONE, 64'h0123_4567_89ab_cdef, '0, 0, 1'b0, '0);
    add_row(OP_LOOKUP, 64'hffff_ffff_0000_0000, '0, 0, 1'b0, '0);
    add_row(OP_INSERT, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 0, 1'b0, '0);
    add_row(OP_LOOKUP, 64'haaaa_aaaa_aaaa_aaaa, '0, 0, 1'b0, '0);
    foreach (directed_rows[i])
      send_request(directed_rows[i].op, directed_rows[i].key, directed_rows[i].data,
                   directed_rows[i].pinned, directed_rows[i].answer);

    // random phases, each setting an age limit and an idling pattern
    for (int p = 0; p < PHASES; p++) begin
      wait_quiet();
      case (p)
        0, 5: limit_setting = AGE_LIMIT_MAX;
        1: limit_setting = 2;
        2: limit_setting = '0;
        3: limit_setting = 7;
        4: limit_setting = 1;
        6: limit_setting = $urandom_range(30, 3);
        default: limit_setting = 3;
      endcase
      set_age_limit(limit_setting);
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 73;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 73;
        end
        default: begin
          send_idle_pct = 24;
          recv_stall_pct = 24;
        end
      endcase
      taken = 0;
      while (taken < REQUESTS_PER_PHASE) begin
        roll = $urandom_range(99);
        if (roll < 45) o = OP_LOOKUP;
        else if (roll < 78) o = OP_INSERT;
        else if (roll < 95) o = OP_TICK;
        else o = OP_NONE;
        // mostly pooled keys so lookups meet their inserts, some noise keys
        if ($urandom_range(99) < 85) k = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
        else k = {$urandom, $urandom};
        d = {$urandom, $urandom};
        send_request(o, k, d, 0, '0);
        taken++;
      end
    end

    // drain the last answers, then a quiet tail to catch stray outputs
    wait_quiet();
    if (errors == 0) $display("tb_ttl_key_value_ring_cache: PASS");
    else $display("tb_ttl_key_value_ring_cache: FAIL");
    $finish;
  end

endmodule

// File: filelist.f
rtl/tkv_pkg.sv
rtl/tkv_cell.sv
rtl/ttl_key_value_ring_cache.sv
dv/tb_ttl_key_value_ring_cache.sv
